// ===== rtl/core/mtq_pkg.sv =====
// Package for the monospace text quad generator.
// Types, register indexes, character codes and vertex order constants.
// No dependencies.
`default_nettype none

package mtq_pkg;

  localparam int COORD_FRAC_BITS_DEF = 20;
  localparam int SCALE_FRAC          = 22;
  localparam int CFG_ADDR_W          = 3;
  localparam int CFG_DATA_W          = 24;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_FIRST_CHAR  = 3'd0,
    CFG_TABLE_SIZE  = 3'd1,
    CFG_CHAR_WIDTH  = 3'd2,
    CFG_CHAR_HEIGHT = 3'd3,
    CFG_SCALE_X     = 3'd4,
    CFG_SCALE_Y     = 3'd5
  } cfg_reg_t;

  localparam logic [7:0]  CHAR_NUL   = 8'd0;
  localparam logic [7:0]  CHAR_NL    = 8'd10;
  localparam logic [7:0]  CHAR_SPACE = 8'd32;
  localparam logic [15:0] UV_MAX     = 16'hFFFF;

  // Vertex order: left-top, right-top, left-bottom, right-top, right-bottom, left-bottom.
  localparam logic [5:0] VERT_RIGHT = 6'b011010;
  localparam logic [5:0] VERT_BOT   = 6'b110100;
  localparam logic [2:0] VERT_LAST  = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SX_MUL,
    ST_SX_ADD,
    ST_SY_MUL,
    ST_SY_ADD,
    ST_DECODE,
    ST_NL_MUL,
    ST_NL_ADD,
    ST_ADV_MUL,
    ST_ADV_ADD,
    ST_LINE_MUL,
    ST_BOT_ADD,
    ST_GADV_MUL,
    ST_GADV_ADD,
    ST_DIV_L,
    ST_DIV_R,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [23:0] dividend;
    logic [8:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/mtq_div.sv =====
// Bit-serial restoring divider for the texture u coordinate.
// 24-bit dividend over 9-bit divisor, 16-bit quotient; uses mtq_pkg.
`default_nettype none

module mtq_div
  import mtq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic        busy;
  logic        done;
  logic [3:0]  cnt;
  logic [8:0]  rem;
  logic [15:0] shreg;
  logic [9:0]  trial;
  logic        ge;

  // Quotient is known to fit 16 bits, so the top byte seeds the remainder.
  assign trial = {rem, shreg[15]};
  assign ge    = trial >= {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem   <= {1'b0, req.dividend[23:16]};
      shreg <= req.dividend[15:0];
    end else if (busy) begin
      rem   <= ge ? 9'(trial - {1'b0, req.divisor}) : trial[8:0];
      shreg <= {shreg[14:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = shreg;

endmodule

`default_nettype wire

// ===== rtl/core/monospace_text_quad_generator.sv =====
// Top level of the monospace text quad generator: sequencer, shared multiplier
// and saturating adder, pen state, output register. Uses mtq_pkg and mtq_div.
//
// Channel  Dir  Handshake                      Contents
// s_axis   in   s_axis_tvalid / s_axis_tready   one text character
// m_axis   out  m_axis_tvalid / m_axis_tready   one glyph vertex
// cfg      in   cfg_we                          register write, no read-back
//
// Per character: an accept, plus the start-x and start-y scaling steps when it
// starts a text, then a decode; NUL or an ended text stops there, while a
// newline/space/non-glyph takes a multiply and an add, and a glyph takes the
// bottom-edge and advance steps, a divider run for each u edge and the quad's vertices.
// Synchronous reset; vertex emission holds while m_axis_tready is low, and a
// new character is taken while the last vertex still waits in the output register.
`default_nettype none

module monospace_text_quad_generator
  import mtq_pkg::*;
#(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // char_code[7:0], start_x_px[19:8], start_y_px[31:20], text_color[63:32]
  input  wire logic [63:0]           s_axis_tdata,
  // text_start[0]
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // vert_x[23:0], vert_y[47:24], tex_u[63:48], tex_v[79:64], vert_color[111:80]
  output logic [111:0]               m_axis_tdata,
  // quad_last
  output logic                       m_axis_tlast,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RSH    = (COORD_FRAC_BITS < SCALE_FRAC) ? SCALE_FRAC - COORD_FRAC_BITS : 0;
  localparam int LSH    = (COORD_FRAC_BITS > SCALE_FRAC) ? COORD_FRAC_BITS - SCALE_FRAC : 0;
  localparam int PROD_W = 37;
  localparam int CONV_W = PROD_W + 1 + LSH;
  localparam int SUM_W  = CONV_W + 2;
  localparam logic signed [CONV_W-1:0] RND =
    (RSH > 0) ? (CONV_W'(1) << ((RSH > 0) ? RSH - 1 : 0)) : '0;
  localparam logic signed [SUM_W-1:0] ONE     = SUM_W'(1) << COORD_FRAC_BITS;
  localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-23){1'b0}}, {23{1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-23){1'b1}}, 23'd0};

  // configuration
  logic [7:0]         first_char_code;
  logic [8:0]         char_table_size;
  logic [7:0]         char_width_px;
  logic [7:0]         char_height_px;
  logic signed [23:0] ndc_scale_x;
  logic signed [23:0] ndc_scale_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_char_code <= 8'd32;
      char_table_size <= 9'd96;
      char_width_px   <= 8'd8;
      char_height_px  <= 8'd16;
      ndc_scale_x     <= '0;
      ndc_scale_y     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        CFG_FIRST_CHAR:  first_char_code <= cfg_wdata[7:0];
        CFG_TABLE_SIZE:  char_table_size <= cfg_wdata[8:0];
        CFG_CHAR_WIDTH:  char_width_px   <= cfg_wdata[7:0];
        CFG_CHAR_HEIGHT: char_height_px  <= cfg_wdata[7:0];
        CFG_SCALE_X:     ndc_scale_x     <= cfg_wdata;
        CFG_SCALE_Y:     ndc_scale_y     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // state
  state_t state, state_next;
  logic   s_xfer;
  logic   out_free;

  logic [7:0]         code;
  logic [11:0]        start_x;
  logic [11:0]        start_y;
  logic [31:0]        start_color;
  logic signed [23:0] pen_x;
  logic signed [23:0] pen_y;
  logic signed [23:0] margin_x;
  logic               text_ended;
  logic [31:0]        color;
  logic signed [23:0] bot;
  logic signed [23:0] xl;
  logic [15:0]        ul;
  logic [15:0]        ur;
  logic [2:0]         vcnt;

  // shared multiplier
  logic signed [12:0]       mul_a;
  logic signed [23:0]       mul_b;
  logic signed [PROD_W-1:0] prod;

  // shared saturating adder
  logic signed [CONV_W-1:0] prod_ext;
  logic signed [CONV_W-1:0] conv_val;
  logic signed [SUM_W-1:0]  addend;
  logic signed [SUM_W-1:0]  sum;
  logic signed [23:0]       sat_val;

  // glyph decode
  logic [7:0] idx;
  logic       is_glyph;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign idx      = code - first_char_code;
  assign is_glyph = (code != CHAR_NL) && (code != CHAR_SPACE) && (code >= first_char_code)
                    && ({1'b0, idx} < char_table_size);

  always_comb begin
    case (state)
      ST_SX_MUL: begin
        mul_a = {1'b0, start_x};
        mul_b = ndc_scale_x;
      end
      ST_SY_MUL: begin
        mul_a = {1'b0, start_y};
        mul_b = ndc_scale_y;
      end
      ST_NL_MUL, ST_LINE_MUL: begin
        mul_a = {5'd0, char_height_px};
        mul_b = ndc_scale_y;
      end
      default: begin
        mul_a = {5'd0, char_width_px};
        mul_b = ndc_scale_x;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a * mul_b);
  end

  assign prod_ext = {{(CONV_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign conv_val = ((prod_ext + RND) >>> RSH) <<< LSH;

  always_comb begin
    case (state)
      ST_SX_ADD:  addend = -ONE;
      ST_SY_ADD:  addend = ONE;
      ST_NL_ADD, ST_BOT_ADD: addend = {{(SUM_W-24){pen_y[23]}}, pen_y};
      default:    addend = {{(SUM_W-24){pen_x[23]}}, pen_x};
    endcase
  end

  assign sum     = {{2{conv_val[CONV_W-1]}}, conv_val} + addend;
  assign sat_val = (sum > SAT_MAX) ? 24'sh7FFFFF :
                   (sum < SAT_MIN) ? -24'sh800000 : sum[23:0];

  // divider requests for the left and right texture u coordinates
  always_comb begin
    div_req.divisor  = char_table_size;
    div_req.start    = 1'b0;
    div_req.dividend = 24'({1'b0, idx, 16'd0} - {17'd0, idx});
    if (state == ST_GADV_ADD) begin
      div_req.start = 1'b1;
    end else if (state == ST_DIV_L && div_rsp.done) begin
      div_req.start    = 1'b1;
      div_req.dividend = 24'({idx + 9'd1, 16'd0} - {16'd0, idx + 9'd1});
    end
  end

  mtq_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_xfer) begin
          state_next = s_axis_tuser ? ST_SX_MUL : ST_DECODE;
        end
      end
      ST_SX_MUL: state_next = ST_SX_ADD;
      ST_SX_ADD: state_next = ST_SY_MUL;
      ST_SY_MUL: state_next = ST_SY_ADD;
      ST_SY_ADD: state_next = ST_DECODE;
      ST_DECODE: begin
        if (text_ended || code == CHAR_NUL) begin
          state_next = ST_IDLE;
        end else if (code == CHAR_NL) begin
          state_next = ST_NL_MUL;
        end else if (is_glyph) begin
          state_next = ST_LINE_MUL;
        end else begin
          state_next = ST_ADV_MUL;
        end
      end
      ST_NL_MUL:   state_next = ST_NL_ADD;
      ST_NL_ADD:   state_next = ST_IDLE;
      ST_ADV_MUL:  state_next = ST_ADV_ADD;
      ST_ADV_ADD:  state_next = ST_IDLE;
      ST_LINE_MUL: state_next = ST_BOT_ADD;
      ST_BOT_ADD:  state_next = ST_GADV_MUL;
      ST_GADV_MUL: state_next = ST_GADV_ADD;
      ST_GADV_ADD: state_next = ST_DIV_L;
      ST_DIV_L: begin
        if (div_rsp.done) begin
          state_next = ST_DIV_R;
        end
      end
      ST_DIV_R: begin
        if (div_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && vcnt == VERT_LAST) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // pen and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x      <= '0;
      pen_y      <= '0;
      margin_x   <= '0;
      text_ended <= 1'b1;
      color      <= '0;
      vcnt       <= '0;
    end else begin
      case (state)
        ST_SX_ADD: begin
          pen_x    <= sat_val;
          margin_x <= sat_val;
        end
        ST_SY_ADD: begin
          pen_y      <= sat_val;
          color      <= start_color;
          text_ended <= 1'b0;
        end
        ST_DECODE: begin
          if (!text_ended && code == CHAR_NUL) begin
            text_ended <= 1'b1;
          end
        end
        ST_NL_ADD: begin
          pen_x <= margin_x;
          pen_y <= sat_val;
        end
        ST_ADV_ADD, ST_GADV_ADD: pen_x <= sat_val;
        ST_DIV_R: vcnt <= '0;
        ST_EMIT: begin
          if (out_free) begin
            vcnt <= vcnt + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // item and glyph payload
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      code        <= s_axis_tdata[7:0];
      start_x     <= s_axis_tdata[19:8];
      start_y     <= s_axis_tdata[31:20];
      start_color <= s_axis_tdata[63:32];
    end
    if (state == ST_BOT_ADD) begin
      bot <= sat_val;
    end
    if (state == ST_GADV_ADD) begin
      xl <= pen_x;
    end
    if (state == ST_DIV_L && div_rsp.done) begin
      ul <= div_rsp.quotient;
    end
    if (state == ST_DIV_R && div_rsp.done) begin
      ur <= div_rsp.quotient;
    end
  end

  // output register
  logic        v_right;
  logic        v_bot;
  logic [23:0] v_x;
  logic [23:0] v_y;
  logic [15:0] v_u;
  logic [15:0] v_v;

  assign v_right = VERT_RIGHT[vcnt];
  assign v_bot   = VERT_BOT[vcnt];
  assign v_x     = v_right ? pen_x : xl;
  assign v_y     = v_bot ? bot : pen_y;
  assign v_u     = v_right ? ur : ul;
  assign v_v     = v_bot ? UV_MAX : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_axis_tdata <= {color, v_v, v_u, v_y, v_x};
      m_axis_tlast <= (vcnt == VERT_LAST);
    end
  end

endmodule

`default_nettype wire
